### src/mglim_pkg.sv
// shared constants, types and codes for the master gain peak limiter
package mglim_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int RED_FRAC_BITS_DEF  = 24;

  localparam int GAIN_BITS          = 16;
  localparam int GAIN_FRAC          = 12;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

  localparam int K_BITS             = 24;
  localparam int K_FRAC             = 32;
  localparam logic [K_BITS-1:0] K_ATTACK  = 24'd4294967;
  localparam logic [K_BITS-1:0] K_RELEASE = 24'd429497;

  localparam int QUEUE_DEPTH        = 2;

  localparam int CFG_INDEX_BITS     = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_STEP,
    BK_UPD,
    BK_MUL_L,
    BK_MUL_R,
    BK_RND_R,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic load;
    logic div_en;
    logic div_last;
    logic step_en;
    logic upd_en;
    logic mull_en;
    logic mulr_en;
    logic rndr_en;
    logic wr_out;
  } bk_ctrl_t;

endpackage

### src/mglim_fifo.sv
// small register queue between the front and back parts
module mglim_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mglim_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### src/mglim_front.sv
// front part: master gain, saturation, magnitudes and block peak metering
module mglim_front #(
  parameter int SAMPLE_BITS = mglim_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_in,
  input  logic                              in_block_end,
  input  logic [mglim_pkg::GAIN_BITS-1:0]   master_gain,
  output logic                              q_push,
  input  logic                              q_full,
  output logic [5*SAMPLE_BITS:0]            q_data
);
  import mglim_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int PW = S + GAIN_BITS + 1;
  localparam logic signed [PW-1:0] RND_G =
    {{(PW-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};
  localparam logic signed [PW-1:0] SMAX_W = {{(PW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN_W = {{(PW-S+1){1'b1}}, {(S-1){1'b0}}};

  function automatic logic signed [S-1:0] sat_gain(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + RND_G) >>> GAIN_FRAC;
    if (r > SMAX_W) begin
      r = SMAX_W;
    end else if (r < SMIN_W) begin
      r = SMIN_W;
    end
    return r[S-1:0];
  endfunction

  function automatic logic [S-1:0] mag(input logic signed [S-1:0] v);
    return v[S-1] ? (~v + 1'b1) : v;
  endfunction

  logic                 s1_v_r, s1_v_nxt;
  logic signed [PW-1:0] prod_l_r, prod_r_r;
  logic                 be_r;
  logic                 acc, fwd;
  logic [S-1:0]         lrun_r, lrun_nxt, rrun_r, rrun_nxt;
  logic signed [S-1:0]  gl, gr;
  logic [S-1:0]         ml, mr, pk, lmax, rmax, lrep, rrep;

  assign in_full  = s1_v_r & q_full;
  assign acc      = in_push & ~in_full;
  assign fwd      = s1_v_r & ~q_full;
  assign s1_v_nxt = acc | (s1_v_r & ~fwd);
  assign q_push   = fwd;

  always_comb begin
    gl   = sat_gain(prod_l_r);
    gr   = sat_gain(prod_r_r);
    ml   = mag(gl);
    mr   = mag(gr);
    pk   = (ml > mr) ? ml : mr;
    lmax = (ml > lrun_r) ? ml : lrun_r;
    rmax = (mr > rrun_r) ? mr : rrun_r;
    lrep = be_r ? lmax : '0;
    rrep = be_r ? rmax : '0;
    lrun_nxt = be_r ? '0 : lmax;
    rrun_nxt = be_r ? '0 : rmax;
  end

  assign q_data = {gl, gr, pk, lrep, rrep, be_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      lrun_r <= '0;
      rrun_r <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (fwd) begin
        lrun_r <= lrun_nxt;
        rrun_r <= rrun_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prod_l_r <= in_left_in * $signed({1'b0, master_gain});
      prod_r_r <= in_right_in * $signed({1'b0, master_gain});
      be_r     <= in_block_end;
    end
  end

endmodule

### src/mglim_back.sv
// back part: limiter target division, reduction follower, output scaling
module mglim_back #(
  parameter int SAMPLE_BITS         = mglim_pkg::SAMPLE_BITS_DEF,
  parameter int REDUCTION_FRAC_BITS = mglim_pkg::RED_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [5*SAMPLE_BITS:0]        q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [SAMPLE_BITS-2:0]        limiter_threshold,
  input  logic                          limiter_enable,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  output logic [SAMPLE_BITS-1:0]        out_left_peak,
  output logic [SAMPLE_BITS-1:0]        out_right_peak,
  output logic                          out_peaks_valid
);
  import mglim_pkg::*;

  localparam int S    = SAMPLE_BITS;
  localparam int R    = REDUCTION_FRAC_BITS;
  localparam int RW   = R + 1;
  localparam int DW   = R + 2;
  localparam int PKW  = DW + K_BITS;
  localparam int POW  = S + R + 2;
  localparam int CNTW = $clog2(R + 1);
  localparam logic [RW-1:0] RED_ONE = {1'b1, {R{1'b0}}};
  localparam logic signed [PKW-1:0] RND_K =
    {{(PKW-K_FRAC){1'b0}}, 1'b1, {(K_FRAC-1){1'b0}}};
  localparam logic signed [POW-1:0] RND_O = {{(POW-R){1'b0}}, 1'b1, {(R-1){1'b0}}};
  localparam logic signed [POW-1:0] SMAX_W = {{(POW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [POW-1:0] SMIN_W = {{(POW-S+1){1'b1}}, {(S-1){1'b0}}};

  function automatic logic signed [S-1:0] sat_out(input logic signed [POW-1:0] p);
    logic signed [POW-1:0] r;
    r = (p + RND_O) >>> R;
    if (r > SMAX_W) begin
      r = SMAX_W;
    end else if (r < SMIN_W) begin
      r = SMIN_W;
    end
    return r[S-1:0];
  endfunction

  bk_state_t state_r, state_nxt;
  bk_ctrl_t  ctl;

  logic signed [S-1:0]   q_gl, q_gr;
  logic [S-1:0]          q_pk, q_lpk, q_rpk;
  logic                  q_pv, q_over;

  logic signed [S-1:0]   gl_r, gr_r, yl_r, yr_r;
  logic [S-1:0]          pk_r, lpk_r, rpk_r, rem_r, rem_nxt;
  logic                  pv_r;
  logic [R-1:0]          quo_r;
  logic [CNTW-1:0]       cnt_r;
  logic [RW-1:0]         tgt_r, red_r;
  logic signed [PKW-1:0] kprod_r, kstep;
  logic signed [POW-1:0] oprod_r;
  logic                  out_v_r, out_v_nxt, slot_free;
  logic [S:0]            dbl, dsub;
  logic                  ge;
  logic signed [DW-1:0]  diff, red_sum;
  logic [K_BITS-1:0]     kcoef;

  assign {q_gl, q_gr, q_pk, q_lpk, q_rpk, q_pv} = q_data;
  assign q_over    = q_pk > {1'b0, limiter_threshold};
  assign slot_free = ~out_v_r | out_pop;
  assign out_empty = ~out_v_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (!limiter_enable) begin
            state_nxt = BK_DONE;
          end else if (q_over) begin
            state_nxt = BK_DIV;
          end else begin
            state_nxt = BK_STEP;
          end
        end
      end
      BK_DIV: begin
        if (cnt_r == CNTW'(R - 1)) begin
          state_nxt = BK_STEP;
        end
      end
      BK_STEP:  state_nxt = BK_UPD;
      BK_UPD:   state_nxt = BK_MUL_L;
      BK_MUL_L: state_nxt = BK_MUL_R;
      BK_MUL_R: state_nxt = BK_RND_R;
      BK_RND_R: state_nxt = BK_DONE;
      BK_DONE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      BK_IDLE:  ctl.load = ~q_empty;
      BK_DIV: begin
        ctl.div_en   = 1'b1;
        ctl.div_last = (cnt_r == CNTW'(R - 1));
      end
      BK_STEP:  ctl.step_en = 1'b1;
      BK_UPD:   ctl.upd_en  = 1'b1;
      BK_MUL_L: ctl.mull_en = 1'b1;
      BK_MUL_R: ctl.mulr_en = 1'b1;
      BK_RND_R: ctl.rndr_en = 1'b1;
      BK_DONE:  ctl.wr_out  = slot_free;
      default:  ctl = '0;
    endcase
  end

  assign q_pop = ctl.load;

  // restoring division, one quotient bit a cycle
  always_comb begin
    dbl     = {rem_r, 1'b0};
    ge      = dbl >= {1'b0, pk_r};
    dsub    = dbl - {1'b0, pk_r};
    rem_nxt = ge ? dsub[S-1:0] : dbl[S-1:0];
  end

  // follower as r + (t - r) * k, rounded
  always_comb begin
    diff    = $signed({1'b0, tgt_r}) - $signed({1'b0, red_r});
    kcoef   = (tgt_r < red_r) ? K_ATTACK : K_RELEASE;
    kstep   = (kprod_r + RND_K) >>> K_FRAC;
    red_sum = $signed({1'b0, red_r}) + kstep[DW-1:0];
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (ctl.wr_out) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      out_v_r <= 1'b0;
      red_r   <= RED_ONE;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      if (ctl.upd_en) begin
        red_r <= red_sum[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      gl_r  <= q_gl;
      gr_r  <= q_gr;
      yl_r  <= q_gl;
      yr_r  <= q_gr;
      pk_r  <= q_pk;
      lpk_r <= q_lpk;
      rpk_r <= q_rpk;
      pv_r  <= q_pv;
      rem_r <= {1'b0, limiter_threshold};
      cnt_r <= '0;
      tgt_r <= RED_ONE;
    end
    if (ctl.div_en) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[R-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (ctl.div_last) begin
        tgt_r <= {1'b0, quo_r[R-2:0], ge};
      end
    end
    if (ctl.step_en) begin
      kprod_r <= diff * $signed(kcoef);
    end
    if (ctl.mull_en) begin
      oprod_r <= gl_r * $signed({1'b0, red_r});
    end
    if (ctl.mulr_en) begin
      yl_r    <= sat_out(oprod_r);
      oprod_r <= gr_r * $signed({1'b0, red_r});
    end
    if (ctl.rndr_en) begin
      yr_r <= sat_out(oprod_r);
    end
    if (ctl.wr_out) begin
      out_left_out    <= yl_r;
      out_right_out   <= yr_r;
      out_left_peak   <= lpk_r;
      out_right_peak  <= rpk_r;
      out_peaks_valid <= pv_r;
    end
  end

endmodule

### src/master_gain_peak_limiter_top.sv
// top level of the stereo master gain, block peak meter and peak limiter
//
// input queue port: push a stereo frame (left, right, block end) while full is
// low. result queue port: while empty is low the oldest result frame is on the
// out_ ports, pop takes it. cfg port: write enable, register index, data; a
// write lands at the clock edge. the user must write only while no frame
// is in flight; the block does not enforce it. a frame passes the gain
// stage register and the two-entry queue, then the back sequencer: idle
// to done with the limiter off; follower step, update, left and right
// multiply, right rounding with the limiter on, first dividing out the
// target reduction (one quotient bit a cycle) when the peak exceeds the
// threshold. the back part takes frames one at a time and sets the throughput.
// reset (synchronous, active low) restores register defaults, sets the
// reduction to unity, clears the running peaks and empties both queues.
// while the receiver stalls the back part finishes the next frame and holds
// it, the queue fills, and full rises once the gain stage is also occupied.
module master_gain_peak_limiter_top #(
  parameter int SAMPLE_BITS         = mglim_pkg::SAMPLE_BITS_DEF,
  parameter int REDUCTION_FRAC_BITS = mglim_pkg::RED_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [SAMPLE_BITS-1:0]          in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]          in_right_in,
  input  logic                                   in_block_end,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [SAMPLE_BITS-1:0]          out_left_out,
  output logic signed [SAMPLE_BITS-1:0]          out_right_out,
  output logic [SAMPLE_BITS-1:0]                 out_left_peak,
  output logic [SAMPLE_BITS-1:0]                 out_right_peak,
  output logic                                   out_peaks_valid,
  input  logic                                   cfg_we,
  input  logic [mglim_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [((SAMPLE_BITS-1 > mglim_pkg::GAIN_BITS) ?
                 SAMPLE_BITS-1 : mglim_pkg::GAIN_BITS)-1:0] cfg_wdata
);
  import mglim_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int QW = 5 * S + 1;

  logic [GAIN_BITS-1:0] master_gain_r;
  logic [S-2:0]         threshold_r;
  logic                 enable_r;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_gain_r <= GAIN_RESET;
      threshold_r   <= '1;
      enable_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:   master_gain_r <= cfg_wdata[GAIN_BITS-1:0];
        CFG_THRESH: threshold_r   <= cfg_wdata[S-2:0];
        CFG_ENABLE: enable_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mglim_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .in_block_end (in_block_end),
    .master_gain  (master_gain_r),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_data       (q_wdata)
  );

  mglim_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mglim_back #(
    .SAMPLE_BITS         (SAMPLE_BITS),
    .REDUCTION_FRAC_BITS (REDUCTION_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_data            (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .limiter_threshold (threshold_r),
    .limiter_enable    (enable_r),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_left_out      (out_left_out),
    .out_right_out     (out_right_out),
    .out_left_peak     (out_left_peak),
    .out_right_peak    (out_right_peak),
    .out_peaks_valid   (out_peaks_valid)
  );

endmodule

### verif/mglim_frame_checker.sv
`timescale 1ns / 1ps
// frame checker for the master gain peak limiter: predicts every result item and compares it
module mglim_frame_checker #(
  parameter int SB    = mglim_pkg::SAMPLE_BITS_DEF,
  parameter int RF    = mglim_pkg::RED_FRAC_BITS_DEF,
  parameter int CFG_W = (SB-1 > mglim_pkg::GAIN_BITS) ? SB-1 : mglim_pkg::GAIN_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  input  logic                                  in_full,
  input  logic signed [SB-1:0]                  in_left_in,
  input  logic signed [SB-1:0]                  in_right_in,
  input  logic                                  in_block_end,
  input  logic                                  out_empty,
  input  logic                                  out_pop,
  input  logic signed [SB-1:0]                  out_left_out,
  input  logic signed [SB-1:0]                  out_right_out,
  input  logic [SB-1:0]                         out_left_peak,
  input  logic [SB-1:0]                         out_right_peak,
  input  logic                                  out_peaks_valid,
  input  logic                                  cfg_we,
  input  logic [mglim_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_wdata,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    peak_reports
);
  import mglim_pkg::*;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic [SB-1:0]        left_pk;
    logic [SB-1:0]        right_pk;
    logic                 pk_valid;
  } frame_result_t;

  localparam longint SMP_MAX = (longint'(1) <<< (SB-1)) - 1;
  localparam longint SMP_MIN = -(longint'(1) <<< (SB-1));
  localparam u64_t   RED_ONE = u64_t'(1) << RF;

  logic [GAIN_BITS-1:0] gain_q;
  logic [SB-2:0]        thresh_q;
  logic                 limit_on;
  logic [RF:0]          reduction;
  logic [SB-1:0]        left_run;
  logic [SB-1:0]        right_run;
  frame_result_t        expected_frames[$];
  int                   errs;
  int                   reports;

  assign fail_count   = errs;
  assign peak_reports = reports;

  function automatic longint clamp_sample(input longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  function automatic frame_result_t gain_and_limit(input logic signed [SB-1:0] left_x,
                                                   input logic signed [SB-1:0] right_x,
                                                   input logic last);
    frame_result_t res;
    longint        gl;
    longint        gr;
    u64_t          ml;
    u64_t          mr;
    u64_t          pk;
    u64_t          target;
    u64_t          k;
    u64_t          next_red;
    gl = clamp_sample((longint'(left_x) * longint'(gain_q)
                       + (longint'(1) <<< (GAIN_FRAC-1))) >>> GAIN_FRAC);
    gr = clamp_sample((longint'(right_x) * longint'(gain_q)
                       + (longint'(1) <<< (GAIN_FRAC-1))) >>> GAIN_FRAC);
    ml = u64_t'(gl < 0 ? -gl : gl);
    mr = u64_t'(gr < 0 ? -gr : gr);
    if (ml > left_run) left_run = ml[SB-1:0];
    if (mr > right_run) right_run = mr[SB-1:0];
    res = '0;
    res.left  = gl[SB-1:0];
    res.right = gr[SB-1:0];
    if (limit_on) begin
      pk = (ml > mr) ? ml : mr;
      target = RED_ONE;
      if (pk > thresh_q) target = (u64_t'(thresh_q) << RF) / pk;
      k = (target < reduction) ? u64_t'(K_ATTACK) : u64_t'(K_RELEASE);
      next_red = (u64_t'(reduction) * ((u64_t'(1) << K_FRAC) - k) + target * k
                  + (u64_t'(1) << (K_FRAC-1))) >> K_FRAC;
      reduction = next_red[RF:0];
      res.left  = SB'(clamp_sample((gl * longint'(reduction)
                                    + (longint'(1) <<< (RF-1))) >>> RF));
      res.right = SB'(clamp_sample((gr * longint'(reduction)
                                    + (longint'(1) <<< (RF-1))) >>> RF));
    end
    if (last) begin
      res.left_pk  = left_run;
      res.right_pk = right_run;
      res.pk_valid = 1'b1;
      left_run  = '0;
      right_run = '0;
    end
    return res;
  endfunction

  function automatic int field_differs(input string name, input longint want, input longint got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      gain_q    = GAIN_RESET;
      thresh_q  = '1;
      limit_on  = 1'b0;
      reduction = RED_ONE[RF:0];
      left_run  = '0;
      right_run = '0;
      expected_frames.delete();
      errs    = 0;
      reports = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:   gain_q   = cfg_wdata[GAIN_BITS-1:0];
          CFG_THRESH: thresh_q = cfg_wdata[SB-2:0];
          CFG_ENABLE: limit_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (expected_frames.size() == 0) begin
          $error("result item arrived with no expected item waiting");
          errs++;
        end else begin
          want = expected_frames.pop_front();
          errs += field_differs("left_out", longint'(want.left), longint'(out_left_out));
          errs += field_differs("right_out", longint'(want.right), longint'(out_right_out));
          errs += field_differs("left_peak", longint'(want.left_pk), longint'(out_left_peak));
          errs += field_differs("right_peak", longint'(want.right_pk),
                                longint'(out_right_peak));
          errs += field_differs("peaks_valid", longint'(want.pk_valid),
                                longint'(out_peaks_valid));
          if (want.pk_valid) reports++;
        end
      end
      if (in_push && !in_full)
        expected_frames.push_back(gain_and_limit(in_left_in, in_right_in, in_block_end));
    end
    pending <= expected_frames.size();
  end

endmodule

### verif/master_gain_peak_limiter_top_tb.sv
`timescale 1ns / 1ps
// testbench top: drives stereo items and register writes into the master gain peak limiter
module master_gain_peak_limiter_top_tb;
  import mglim_pkg::*;

  localparam int SB               = SAMPLE_BITS_DEF;
  localparam int CFG_W            = (SB-1 > GAIN_BITS) ? SB-1 : GAIN_BITS;
  localparam int IDLE_PCT         = 29;
  localparam int HOLD_CYCLES      = 300;
  localparam int NUM_PHASES       = 10;
  localparam int FRAMES_PER_PHASE = 158;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-2:0]        THRESH_MAX = '1;

  typedef enum logic [1:0] {
    STY_LOUD,
    STY_QUIET,
    STY_NOISE
  } frame_style_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_push = 1'b0;
  logic                      in_full;
  logic signed [SB-1:0]      in_left_in = '0;
  logic signed [SB-1:0]      in_right_in = '0;
  logic                      in_block_end = 1'b0;
  logic                      out_empty;
  logic                      out_pop = 1'b0;
  logic signed [SB-1:0]      out_left_out;
  logic signed [SB-1:0]      out_right_out;
  logic [SB-1:0]             out_left_peak;
  logic [SB-1:0]             out_right_peak;
  logic                      out_peaks_valid;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  int   fail_count;
  int   pending;
  int   peak_reports;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;
  int   holds_done = 0;
  int   frames_sent = 0;
  int   settings_used = 0;

  always #6 clk = ~clk;

  master_gain_peak_limiter_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .in_block_end    (in_block_end),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_left_peak   (out_left_peak),
    .out_right_peak  (out_right_peak),
    .out_peaks_valid (out_peaks_valid),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  mglim_frame_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_left_in      (in_left_in),
    .in_right_in     (in_right_in),
    .in_block_end    (in_block_end),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_left_peak   (out_left_peak),
    .out_right_peak  (out_right_peak),
    .out_peaks_valid (out_peaks_valid),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .peak_reports    (peak_reports)
  );

  task automatic send_frame(input logic signed [SB-1:0] left_x,
                            input logic signed [SB-1:0] right_x, input logic last);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_left_in   <= left_x;
    in_right_in  <= right_x;
    in_block_end <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // unused upper bits and the spare index get junk, which must be ignored
  task automatic program_regs(input logic [GAIN_BITS-1:0] gain, input logic [SB-2:0] thresh,
                              input logic enable);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    wait_drained();
    write_reg(CFG_GAIN, {junk[CFG_W-1:GAIN_BITS], gain});
    write_reg(CFG_THRESH, thresh);
    write_reg(CFG_ENABLE, {junk[CFG_W-2:0], enable});
    write_reg(CFG_UNUSED, junk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [SB-1:0] pick_sample(input frame_style_t style);
    logic [SB-1:0] mag;
    case (style)
      STY_LOUD: begin
        if ($urandom_range(15) == 0) return SAMPLE_MIN;
        mag = SB'($urandom_range(2**(SB-1) - 1, 2**(SB-2)));
      end
      STY_QUIET: mag = SB'($urandom_range(2**14));
      default: return SB'($urandom);
    endcase
    return $urandom_range(1) ? -$signed(mag) : $signed(mag);
  endfunction

  // receiver: random pops, with one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    frame_style_t         burst_style;
    frame_style_t         style;
    int                   burst_left;
    int                   meter_left;
    logic signed [SB-1:0] left_x;
    logic                 last;
    burst_left = 0;
    meter_left = 8;
    burst_style = STY_LOUD;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: unity gain, limiter off
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_frame('0, '0, 1'b0);
    send_frame(-24'sd1, 24'sd1, 1'b1);
    send_frame(24'sd1, -24'sd1, 1'b1);
    // full gain saturates both ways, then zero gain mutes
    program_regs(16'hFFFF, THRESH_MAX, 1'b0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(24'sd4096, -24'sd4096, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    program_regs('0, THRESH_MAX, 1'b0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    // limiter attack then release
    program_regs(GAIN_RESET, 23'd1048576, 1'b1);
    repeat (4) send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(24'sd100, -24'sd100, 1'b0);
    send_frame(24'sd100, -24'sd100, 1'b0);
    send_frame(SAMPLE_MIN, 24'sd5, 1'b1);
    // zero threshold: silence never exceeds it, anything else targets zero
    program_regs(GAIN_RESET, '0, 1'b1);
    send_frame('0, '0, 1'b0);
    send_frame(24'sd1, '0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs(GAIN_RESET, THRESH_MAX, 1'b1);
        1: program_regs(GAIN_RESET, 23'd2097152, 1'b1);
        2: program_regs(16'hFFFF, 23'd1, 1'b1);
        3: program_regs('0, 23'd4194304, 1'b1);
        4: program_regs(16'd8192, '0, 1'b1);
        5: program_regs(GAIN_BITS'($urandom), (SB-1)'($urandom), 1'b0);
        6: program_regs(GAIN_RESET, 23'd4194304, 1'b1);
        7: program_regs(16'd1, THRESH_MAX, 1'b1);
        8: program_regs(GAIN_BITS'($urandom), (SB-1)'($urandom), 1'b1);
        default: program_regs(GAIN_BITS'($urandom_range(20000, 2000)), 23'd6000000, 1'b1);
      endcase
      no_idle = (p == 1);
      for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
        if (p == 2 && i == 20) hold_req = 1'b1;
        if (p == 6 && i == 80) wait_drained();
        if (burst_left == 0) begin
          burst_style = frame_style_t'($urandom_range(1));
          burst_left = $urandom_range(60, 4);
        end
        burst_left--;
        style = ($urandom_range(99) < 15) ? STY_NOISE : burst_style;
        left_x = pick_sample(style);
        meter_left--;
        last = (meter_left == 0);
        if (last) meter_left = $urandom_range(24, 1);
        send_frame(left_x, ($urandom_range(7) == 0) ? left_x : pick_sample(style), last);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d items over %0d register settings, %0d peak reports, %0d long holds",
             frames_sent, settings_used, peak_reports, holds_done);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS master_gain_peak_limiter_top");
    end else begin
      $display("FAIL master_gain_peak_limiter_top");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d items still expected", pending);
    $display("FAIL master_gain_peak_limiter_top");
    $finish;
  end

endmodule

### master_gain_peak_limiter_top.f
src/mglim_pkg.sv
src/mglim_fifo.sv
src/mglim_front.sv
src/mglim_back.sv
src/master_gain_peak_limiter_top.sv
verif/mglim_frame_checker.sv
verif/master_gain_peak_limiter_top_tb.sv
